// ===== rtl/core/peer_presence_table_with_aging_macros.svh =====
// Assertion macros used by the peer presence table checker.
`ifndef PEER_PRESENCE_TABLE_WITH_AGING_MACROS_SVH
`define PEER_PRESENCE_TABLE_WITH_AGING_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ppt_pkg.sv =====
// Types and constants of the peer presence table.
package ppt_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 5;

  localparam int unsigned InTdataW = 104;
  localparam int unsigned OutTdataW = 72;

  localparam int unsigned OutFoundBit = 0;
  localparam int unsigned OutOnlineBit = 1;
  localparam int unsigned OutDropBit = 71;

  localparam logic [1:0] RegLocalId = 2'd0;
  localparam logic [1:0] RegOfflineTimeout = 2'd1;
  localparam logic [1:0] RegSweepInterval = 2'd2;

  localparam logic [WordW-1:0] LocalIdReset = 32'd0;
  localparam logic [WordW-1:0] OfflineTimeoutReset = 32'd60000;
  localparam logic [WordW-1:0] SweepIntervalReset = 32'd30000;

  localparam logic OpPacket = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LK_RD,
    ST_LK_CMP,
    ST_WRITE,
    ST_SWP_CHK,
    ST_SWP_RD,
    ST_SWP_CMP,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/core/peer_presence_table_with_aging.sv =====
// Top level of the peer presence table with aging sweep.
// A packet runs at most a lookup, a write, an aging sweep and a final lookup, in that order.
// Each scanned entry takes a read state and a compare state, set by the single-port RAM and the shared subtractor.
// A new item can be taken in the cycle after a result is loaded, even while that result waits.
// rst_ni clears the count, the online flags and the last sweep time, and sets the registers to their reset values.
module peer_presence_table_with_aging #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // peer_id, source_addr, now_ms, has_records, then zero padding.
  input  logic [ppt_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // opcode.
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // found, online, peer_addr, seen_time, entry_count, table_full_drop.
  output logic [ppt_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [ppt_pkg::WordW-1:0]      cfg_data_i
);
  import ppt_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RamW = 3 * WordW;

  state_e state_q, state_d;

  logic [WordW-1:0] local_id_q, timeout_q, interval_q;
  logic [WordW-1:0] item_id_q, item_addr_q, item_now_q;
  logic             item_op_q, item_rec_q;
  logic             in_accept;

  logic [CntW-1:0]        idx_q, idx_d, count_q, count_d;
  logic [TABLE_DEPTH-1:0] online_q, online_d;
  logic [WordW-1:0]       last_sweep_q, last_sweep_d;
  logic                   final_q, final_d, drop_q, drop_d;

  logic             res_found_q, res_found_d, res_online_q, res_online_d;
  logic [WordW-1:0] res_addr_q, res_addr_d, res_seen_q, res_seen_d;

  logic                 out_valid_q, out_valid_d, out_load;
  logic [OutTdataW-1:0] out_tdata_q;
  logic [31:0]          count_ext;

  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [RamW-1:0] ram_wdata, ram_rdata;
  logic [WordW-1:0] rd_uid, rd_ip, rd_seen;

  logic [WordW-1:0] sub_a, sub_b, sub_lim, sub_diff;
  logic             sub_zero, sub_over;
  logic             idx_lt_cnt, room, record;

  assign rd_uid  = ram_rdata[3*WordW-1:2*WordW];
  assign rd_ip   = ram_rdata[2*WordW-1:WordW];
  assign rd_seen = ram_rdata[WordW-1:0];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign idx_lt_cnt = (idx_q < count_q);
  assign room       = (count_q < CntW'(TABLE_DEPTH));
  assign record     = (s_axis_tuser_i == OpPacket) && s_axis_tdata_i[96]
                      && (s_axis_tdata_i[31:0] != local_id_q);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  // Shared subtract-compare unit: equality for lookups, wrapped age checks for sweeps.
  always_comb begin
    sub_a   = item_now_q;
    sub_b   = last_sweep_q;
    sub_lim = interval_q;
    case (state_q)
      ST_LK_CMP: begin
        sub_a = item_id_q;
        sub_b = rd_uid;
      end
      ST_SWP_CMP: begin
        sub_b   = rd_seen;
        sub_lim = timeout_q;
      end
      default: begin
      end
    endcase
  end

  assign sub_diff = sub_a - sub_b;
  assign sub_zero = (sub_diff == '0);
  assign sub_over = (sub_diff > sub_lim);

  ppt_ram #(
    .Width(RamW),
    .Depth(TABLE_DEPTH),
    .AddrW(IdxW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (record || s_axis_tuser_i == OpQuery) begin
            state_d = ST_LK_RD;
          end else begin
            state_d = ST_SWP_CHK;
          end
        end
      end
      ST_LK_RD: begin
        if (idx_lt_cnt) begin
          state_d = ST_LK_CMP;
        end else if (final_q) begin
          state_d = ST_OUT;
        end else if (room) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_SWP_CHK;
        end
      end
      ST_LK_CMP: begin
        if (sub_zero) begin
          state_d = final_q ? ST_OUT : ST_WRITE;
        end else begin
          state_d = ST_LK_RD;
        end
      end
      ST_WRITE:   state_d = ST_SWP_CHK;
      ST_SWP_CHK: state_d = sub_over ? ST_SWP_RD : ST_LK_RD;
      ST_SWP_RD:  state_d = idx_lt_cnt ? ST_SWP_CMP : ST_LK_RD;
      ST_SWP_CMP: state_d = ST_SWP_RD;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d        = idx_q;
    count_d      = count_q;
    online_d     = online_q;
    last_sweep_d = last_sweep_q;
    final_d      = final_q;
    drop_d       = drop_q;
    res_found_d  = res_found_q;
    res_online_d = res_online_q;
    res_addr_d   = res_addr_q;
    res_seen_d   = res_seen_q;
    ram_we       = 1'b0;
    ram_addr     = idx_q[IdxW-1:0];
    ram_wdata    = {item_id_q, item_addr_q, item_now_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d   = '0;
          final_d = (s_axis_tuser_i == OpQuery);
          drop_d  = 1'b0;
        end
      end
      ST_LK_RD: begin
        if (!idx_lt_cnt) begin
          if (final_q) begin
            res_found_d  = 1'b0;
            res_online_d = 1'b0;
            res_addr_d   = '0;
            res_seen_d   = '0;
          end else if (!room) begin
            drop_d = 1'b1;
          end
        end
      end
      ST_LK_CMP: begin
        if (sub_zero) begin
          if (final_q) begin
            res_found_d  = 1'b1;
            res_online_d = online_q[idx_q[IdxW-1:0]];
            res_addr_d   = rd_ip;
            res_seen_d   = rd_seen;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_WRITE: begin
        ram_we = 1'b1;
        online_d[idx_q[IdxW-1:0]] = 1'b1;
        if (idx_q == count_q) begin
          count_d = count_q + 1'b1;
        end
      end
      ST_SWP_CHK: begin
        idx_d = '0;
        if (sub_over) begin
          last_sweep_d = item_now_q;
        end else begin
          final_d = 1'b1;
        end
      end
      ST_SWP_RD: begin
        if (!idx_lt_cnt) begin
          idx_d   = '0;
          final_d = 1'b1;
        end
      end
      ST_SWP_CMP: begin
        if (sub_over) begin
          online_d[idx_q[IdxW-1:0]] = 1'b0;
        end
        idx_d = idx_q + 1'b1;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !m_axis_tready_i) || out_load;
  assign count_ext   = 32'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      count_q      <= '0;
      online_q     <= '0;
      last_sweep_q <= '0;
      final_q      <= 1'b0;
      drop_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      local_id_q   <= LocalIdReset;
      timeout_q    <= OfflineTimeoutReset;
      interval_q   <= SweepIntervalReset;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      online_q     <= online_d;
      last_sweep_q <= last_sweep_d;
      final_q      <= final_d;
      drop_q       <= drop_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegLocalId:        local_id_q <= cfg_data_i;
          RegOfflineTimeout: timeout_q  <= cfg_data_i;
          RegSweepInterval:  interval_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_op_q   <= s_axis_tuser_i;
      item_id_q   <= s_axis_tdata_i[31:0];
      item_addr_q <= s_axis_tdata_i[63:32];
      item_now_q  <= s_axis_tdata_i[95:64];
      item_rec_q  <= s_axis_tdata_i[96];
    end
    res_found_q  <= res_found_d;
    res_online_q <= res_online_d;
    res_addr_q   <= res_addr_d;
    res_seen_q   <= res_seen_d;
    if (out_load) begin
      out_tdata_q <= {drop_q && (item_op_q == OpPacket) && item_rec_q,
                      count_ext[CountW-1:0], res_seen_q, res_addr_q,
                      res_online_q, res_found_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;

endmodule

// ===== rtl/core/ppt_ram.sv =====
// Generic single-port RAM with a registered read.
module ppt_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ppt_checker.sv =====
// Port-level checker for the peer presence table, bound to the top level.
`include "peer_presence_table_with_aging_macros.svh"

module ppt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [ppt_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import ppt_pkg::*;

  logic found, online, drop, rest_zero;

  assign found     = m_axis_tdata_o[OutFoundBit];
  assign online    = m_axis_tdata_o[OutOnlineBit];
  assign drop      = m_axis_tdata_o[OutDropBit];
  assign rest_zero = (m_axis_tdata_o[65:2] == '0);

  `PPT_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input ready right after a transfer")
  `PPT_ASSERT_NOW(a_miss_is_zero, m_axis_tvalid_o && !found, !online && rest_zero, "missing peer reports nonzero fields")
  `PPT_ASSERT_NOW(a_drop_not_found, m_axis_tvalid_o && drop, !found, "dropped peer reported as present")
  `PPT_ASSERT_NEXT(a_result_holds, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

endmodule

bind peer_presence_table_with_aging ppt_checker u_ppt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
